// ===== src/u8u16_pkg.sv =====
// Package for the UTF-8 to UTF-16 transcoder: payload types, error codes,
// decode constants and the result builder.
// No dependencies.
package u8u16_pkg;

  localparam int unsigned PartialW = 15;

  localparam logic [7:0] CONT_MASK  = 8'b1100_0000;
  localparam logic [7:0] CONT_TAG   = 8'b1000_0000;
  localparam logic [7:0] LEAD2_MASK = 8'b1110_0000;
  localparam logic [7:0] LEAD2_TAG  = 8'b1100_0000;
  localparam logic [7:0] LEAD3_MASK = 8'b1111_0000;
  localparam logic [7:0] LEAD3_TAG  = 8'b1110_0000;
  localparam logic [7:0] LEAD4_MASK = 8'b1111_1000;
  localparam logic [7:0] LEAD4_TAG  = 8'b1111_0000;

  localparam logic [20:0] SURR_LO    = 21'h00D800;
  localparam logic [20:0] SURR_HI    = 21'h00DFFF;
  localparam logic [20:0] SUPP_BASE  = 21'h010000;
  localparam logic [20:0] CP_MAX     = 21'h10FFFF;
  localparam logic [5:0]  HI_SURR_TAG = 6'b110110;
  localparam logic [5:0]  LO_SURR_TAG = 6'b110111;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_BAD_CONT  = 3'd1,
    ERR_BAD_LEAD  = 3'd2,
    ERR_TRUNC     = 3'd3,
    ERR_ZERO      = 3'd4,
    ERR_UNENC     = 3'd5
  } err_code_t;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       string_last;
  } in_item_t;

  typedef struct packed {
    logic [15:0] unit_out;
    logic        has_unit;
    logic        run_last;
    logic        string_end;
    err_code_t   error_code;
  } out_item_t;

  typedef struct packed {
    logic [1:0] n;
    out_item_t  r0;
    out_item_t  r1;
  } dec_res_t;

  function automatic out_item_t mk_res(logic [15:0] unit, logic has, err_code_t err);
    out_item_t r;
    r.unit_out   = unit;
    r.has_unit   = has;
    r.run_last   = 1'b0;
    r.string_end = 1'b0;
    r.error_code = err;
    return r;
  endfunction

endpackage

// ===== src/u8u16_decoder.sv =====
// Combinational byte decoder: results and next sequence state for one byte.
// Depends on u8u16_pkg.
module u8u16_decoder (
  input  u8u16_pkg::in_item_t                  item,
  input  logic [u8u16_pkg::PartialW-1:0]       pv,
  input  logic [1:0]                           due,
  output u8u16_pkg::dec_res_t                  dec,
  output logic [u8u16_pkg::PartialW-1:0]       pv_nxt,
  output logic [1:0]                           due_nxt
);

  logic [7:0]                        b;
  logic                              last;
  logic                              lead_has;
  u8u16_pkg::out_item_t              lead_res;
  logic                              lead_open;
  logic [u8u16_pkg::PartialW-1:0]    lead_bits;
  logic [1:0]                        lead_due;
  logic [20:0]                       cp;
  logic [20:0]                       sv;
  logic                              cp_bad;
  logic                              cp_pair;

  assign b    = item.byte_in;
  assign last = item.string_last;

  assign cp      = {pv, b[5:0]};
  assign sv      = cp - u8u16_pkg::SUPP_BASE;
  assign cp_bad  = ((cp >= u8u16_pkg::SURR_LO) && (cp <= u8u16_pkg::SURR_HI)) ||
                   (cp > u8u16_pkg::CP_MAX);
  assign cp_pair = (cp >= u8u16_pkg::SUPP_BASE);

  // lead byte classification
  always_comb begin
    lead_has  = 1'b1;
    lead_res  = u8u16_pkg::mk_res(16'h0000, 1'b0, u8u16_pkg::ERR_BAD_LEAD);
    lead_open = 1'b0;
    lead_bits = '0;
    lead_due  = 2'd0;
    priority if (b == 8'h00) begin
      lead_res = u8u16_pkg::mk_res(16'h0000, 1'b0,
                                   last ? u8u16_pkg::ERR_NONE : u8u16_pkg::ERR_ZERO);
    end else if (b[7] == 1'b0) begin
      lead_res = u8u16_pkg::mk_res({8'h00, b}, 1'b1, u8u16_pkg::ERR_NONE);
    end else if ((b & u8u16_pkg::LEAD2_MASK) == u8u16_pkg::LEAD2_TAG) begin
      lead_bits = {10'd0, b[4:0]};
      lead_due  = 2'd1;
    end else if ((b & u8u16_pkg::LEAD3_MASK) == u8u16_pkg::LEAD3_TAG) begin
      lead_bits = {11'd0, b[3:0]};
      lead_due  = 2'd2;
    end else if ((b & u8u16_pkg::LEAD4_MASK) == u8u16_pkg::LEAD4_TAG) begin
      lead_bits = {12'd0, b[2:0]};
      lead_due  = 2'd3;
    end else begin
      lead_res = u8u16_pkg::mk_res(16'h0000, 1'b0, u8u16_pkg::ERR_BAD_LEAD);
    end
    if (lead_due != 2'd0) begin
      lead_has  = last;
      lead_open = !last;
      lead_res  = u8u16_pkg::mk_res(16'h0000, 1'b0, u8u16_pkg::ERR_TRUNC);
    end
  end

  always_comb begin
    dec.n   = 2'd0;
    dec.r0  = u8u16_pkg::mk_res(16'h0000, 1'b0, u8u16_pkg::ERR_NONE);
    dec.r1  = u8u16_pkg::mk_res(16'h0000, 1'b0, u8u16_pkg::ERR_NONE);
    pv_nxt  = pv;
    due_nxt = due;
    if (due != 2'd0) begin
      priority if ((b & u8u16_pkg::CONT_MASK) == u8u16_pkg::CONT_TAG) begin
        if (due == 2'd1) begin
          pv_nxt  = '0;
          due_nxt = 2'd0;
          priority if (cp_bad) begin
            dec.r0 = u8u16_pkg::mk_res(16'h0000, 1'b0, u8u16_pkg::ERR_UNENC);
            dec.n  = 2'd1;
          end else if (cp_pair) begin
            dec.r0 = u8u16_pkg::mk_res({u8u16_pkg::HI_SURR_TAG, sv[19:10]}, 1'b1,
                                       u8u16_pkg::ERR_NONE);
            dec.r1 = u8u16_pkg::mk_res({u8u16_pkg::LO_SURR_TAG, sv[9:0]}, 1'b1,
                                       u8u16_pkg::ERR_NONE);
            dec.n  = 2'd2;
          end else begin
            dec.r0 = u8u16_pkg::mk_res(cp[15:0], 1'b1, u8u16_pkg::ERR_NONE);
            dec.n  = 2'd1;
          end
        end else begin
          pv_nxt  = {pv[8:0], b[5:0]};
          due_nxt = due - 2'd1;
          if (last) begin
            dec.r0 = u8u16_pkg::mk_res(16'h0000, 1'b0, u8u16_pkg::ERR_TRUNC);
            dec.n  = 2'd1;
          end
        end
      end else if (b == 8'h00) begin
        pv_nxt  = '0;
        due_nxt = 2'd0;
        dec.r0  = u8u16_pkg::mk_res(16'h0000, 1'b0,
                                    last ? u8u16_pkg::ERR_TRUNC : u8u16_pkg::ERR_ZERO);
        dec.n   = 2'd1;
      end else begin
        // broken sequence: flag it, then treat the byte as a fresh lead
        pv_nxt  = '0;
        due_nxt = 2'd0;
        dec.r0  = u8u16_pkg::mk_res(16'h0000, 1'b0, u8u16_pkg::ERR_BAD_CONT);
        dec.n   = 2'd1;
        if (lead_has) begin
          dec.r1 = lead_res;
          dec.n  = 2'd2;
        end
        if (lead_open) begin
          pv_nxt  = lead_bits;
          due_nxt = lead_due;
        end
      end
    end else begin
      if (lead_has) begin
        dec.r0 = lead_res;
        dec.n  = 2'd1;
      end
      if (lead_open) begin
        pv_nxt  = lead_bits;
        due_nxt = lead_due;
      end
    end
    if (last) begin
      pv_nxt  = '0;
      due_nxt = 2'd0;
    end
    if (dec.n == 2'd1) begin
      dec.r0.run_last   = 1'b1;
      dec.r0.string_end = last;
    end else if (dec.n == 2'd2) begin
      dec.r1.run_last   = 1'b1;
      dec.r1.string_end = last;
    end
  end

endmodule

// ===== src/u8u16_out_buf.sv =====
// Two-entry result buffer: loads up to two results of one byte, drains one per transfer.
// Depends on u8u16_pkg.
module u8u16_out_buf (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  u8u16_pkg::dec_res_t   dec,
  output logic                  free,
  output logic                  out_valid,
  input  logic                  out_ready,
  output u8u16_pkg::out_item_t  out_data
);

  logic [1:0]           cnt_r, cnt_nxt;
  u8u16_pkg::out_item_t res0_r, res0_nxt;
  u8u16_pkg::out_item_t res1_r, res1_nxt;

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = res0_r;
  assign free      = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);

  always_comb begin
    cnt_nxt  = cnt_r;
    res0_nxt = res0_r;
    res1_nxt = res1_r;
    if (load) begin
      cnt_nxt  = dec.n;
      res0_nxt = dec.r0;
      res1_nxt = dec.r1;
    end else if (out_valid && out_ready) begin
      cnt_nxt  = cnt_r - 2'd1;
      res0_nxt = res1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    res0_r <= res0_nxt;
    res1_r <= res1_nxt;
  end

endmodule

// ===== src/utf8_to_utf16_transcoder_unit.sv =====
// Top level of the UTF-8 to UTF-16 transcoder: input register, sequence state, decoder
// and result buffer. Depends on u8u16_pkg, u8u16_decoder and u8u16_out_buf.
//
// One UTF-8 byte is taken per cycle while the result buffer has room and yields zero, one
// or two UTF-16 results. Bytes that yield at most one result sustain one byte per cycle
// while out_ready is high; a byte that yields two (surrogate pair, or a broken sequence
// followed by a new result) holds the input while the two-entry result buffer drains.
// Faults come out as results with has_unit low and an error code; the last result of a
// byte carries run_last, and of a string's last byte also string_end.
module utf8_to_utf16_transcoder_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  u8u16_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output u8u16_pkg::out_item_t  out_data
);

  logic                              s1_valid_r, s1_valid_nxt;
  u8u16_pkg::in_item_t               s1_data_r, s1_data_nxt;
  logic [u8u16_pkg::PartialW-1:0]    pv_r, pv_nxt;
  logic [1:0]                        due_r, due_nxt;
  u8u16_pkg::dec_res_t               dec;
  logic                              buf_free;
  logic                              s1_take;
  logic                              in_xfer;

  u8u16_decoder u_dec (
    .item    (s1_data_r),
    .pv      (pv_r),
    .due     (due_r),
    .dec     (dec),
    .pv_nxt  (pv_nxt),
    .due_nxt (due_nxt)
  );

  u8u16_out_buf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (s1_take && (dec.n != 2'd0)),
    .dec       (dec),
    .free      (buf_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign s1_take  = s1_valid_r && ((dec.n == 2'd0) || buf_free);
  assign in_ready = !s1_valid_r || s1_take;
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_data_nxt  = s1_data_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
      s1_data_nxt  = in_data;
    end else if (s1_take) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      pv_r       <= '0;
      due_r      <= 2'd0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (s1_take) begin
        pv_r  <= pv_nxt;
        due_r <= due_nxt;
      end
    end
    s1_data_r <= s1_data_nxt;
  end

`ifndef SYNTHESIS
  a_unit_no_err : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.has_unit) |-> (out_data.error_code == u8u16_pkg::ERR_NONE))
    else $error("result with a unit carries an error code");

  a_empty_unit_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.has_unit) |-> (out_data.unit_out == 16'h0000))
    else $error("result without a unit has nonzero unit_out");

  a_end_is_run_last : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.string_end) |-> out_data.run_last)
    else $error("string_end without run_last");

  a_last_clears : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_take && s1_data_r.string_last) |=> ((due_r == 2'd0) && (pv_r == '0)))
    else $error("sequence state not cleared after string end");

  a_last_has_result : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_data_r.string_last) |-> (dec.n != 2'd0))
    else $error("string's last byte produced no result");
`endif

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for utf8_to_utf16_transcoder_unit: directed and random UTF-8
// byte streams against a built-in UTF-16 result predictor with a result scoreboard.
// Depends on u8u16_pkg and the transcoder RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  class unit_tracker;
    logic [20:0]          code_bits;
    logic [1:0]           cont_due;
    u8u16_pkg::out_item_t step_units[$];
    u8u16_pkg::out_item_t pending_units[$];
    int                   errors;

    function new();
      code_bits = '0;
      cont_due  = '0;
      errors    = 0;
    endfunction

    function int pending();
      return pending_units.size();
    endfunction

    function void queue_unit(logic [15:0] unit, logic has, u8u16_pkg::err_code_t err);
      u8u16_pkg::out_item_t r;
      r.unit_out   = unit;
      r.has_unit   = has;
      r.run_last   = 1'b0;
      r.string_end = 1'b0;
      r.error_code = err;
      step_units   = {step_units, r};
    endfunction

    function void clear_seq();
      code_bits = '0;
      cont_due  = '0;
    endfunction

    function void open_seq(logic [20:0] bits, logic [1:0] due, logic last);
      code_bits = bits;
      cont_due  = due;
      if (last) begin
        queue_unit(16'h0, 1'b0, u8u16_pkg::ERR_TRUNC);
        clear_seq();
      end
    endfunction

    function void lead_byte(logic [7:0] b, logic last);
      if (b == 8'h00) begin
        queue_unit(16'h0, 1'b0, last ? u8u16_pkg::ERR_NONE : u8u16_pkg::ERR_ZERO);
      end else if (!b[7]) begin
        queue_unit({8'h00, b}, 1'b1, u8u16_pkg::ERR_NONE);
      end else if ((b & u8u16_pkg::LEAD2_MASK) == u8u16_pkg::LEAD2_TAG) begin
        open_seq({16'h0, b[4:0]}, 2'd1, last);
      end else if ((b & u8u16_pkg::LEAD3_MASK) == u8u16_pkg::LEAD3_TAG) begin
        open_seq({17'h0, b[3:0]}, 2'd2, last);
      end else if ((b & u8u16_pkg::LEAD4_MASK) == u8u16_pkg::LEAD4_TAG) begin
        open_seq({18'h0, b[2:0]}, 2'd3, last);
      end else begin
        queue_unit(16'h0, 1'b0, u8u16_pkg::ERR_BAD_LEAD);
      end
    endfunction

    function void finish_code_point(logic [20:0] cp);
      logic [20:0] ofs;
      if ((cp >= u8u16_pkg::SURR_LO && cp <= u8u16_pkg::SURR_HI) ||
          cp > u8u16_pkg::CP_MAX) begin
        queue_unit(16'h0, 1'b0, u8u16_pkg::ERR_UNENC);
      end else if (cp >= u8u16_pkg::SUPP_BASE) begin
        ofs = cp - u8u16_pkg::SUPP_BASE;
        queue_unit({u8u16_pkg::HI_SURR_TAG, ofs[19:10]}, 1'b1, u8u16_pkg::ERR_NONE);
        queue_unit({u8u16_pkg::LO_SURR_TAG, ofs[9:0]}, 1'b1, u8u16_pkg::ERR_NONE);
      end else begin
        queue_unit(cp[15:0], 1'b1, u8u16_pkg::ERR_NONE);
      end
    endfunction

    // Expected results of one accepted byte.
    function void predict_units(u8u16_pkg::in_item_t it);
      logic [7:0] b;
      logic       last;
      b    = it.byte_in;
      last = it.string_last;
      step_units.delete();
      if (cont_due != 2'd0) begin
        if ((b & u8u16_pkg::CONT_MASK) == u8u16_pkg::CONT_TAG) begin
          code_bits = {code_bits[14:0], b[5:0]};
          cont_due  = cont_due - 2'd1;
          if (cont_due == 2'd0) begin
            finish_code_point(code_bits);
            code_bits = '0;
          end else if (last) begin
            queue_unit(16'h0, 1'b0, u8u16_pkg::ERR_TRUNC);
            clear_seq();
          end
        end else if (b == 8'h00) begin
          clear_seq();
          queue_unit(16'h0, 1'b0, last ? u8u16_pkg::ERR_TRUNC : u8u16_pkg::ERR_ZERO);
        end else begin
          clear_seq();
          queue_unit(16'h0, 1'b0, u8u16_pkg::ERR_BAD_CONT);
          lead_byte(b, last);
        end
      end else begin
        lead_byte(b, last);
      end
      if (last) clear_seq();
      if (step_units.size() > 0) begin
        step_units[step_units.size() - 1].run_last   = 1'b1;
        step_units[step_units.size() - 1].string_end = last;
      end
      pending_units = {pending_units, step_units};
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
      errors++;
    endtask

    task check_unit(u8u16_pkg::out_item_t got);
      u8u16_pkg::out_item_t want;
      if (pending_units.size() == 0) begin
        report_mismatch("unexpected transfer", 32'(got), 32'h0);
      end else begin
        want = pending_units.pop_front();
        if (got.unit_out !== want.unit_out)
          report_mismatch("unit_out", 32'(got.unit_out), 32'(want.unit_out));
        if (got.has_unit !== want.has_unit)
          report_mismatch("has_unit", 32'(got.has_unit), 32'(want.has_unit));
        if (got.run_last !== want.run_last)
          report_mismatch("run_last", 32'(got.run_last), 32'(want.run_last));
        if (got.string_end !== want.string_end)
          report_mismatch("string_end", 32'(got.string_end), 32'(want.string_end));
        if (got.error_code !== want.error_code)
          report_mismatch("error_code", 32'(got.error_code), 32'(want.error_code));
      end
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  u8u16_pkg::in_item_t   in_data;
  logic                  out_valid;
  logic                  out_ready;
  u8u16_pkg::out_item_t  out_data;

  unit_tracker book;
  int          sent_bytes;
  int          seen_units;
  bit          no_idle;

  utf8_to_utf16_transcoder_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("testbench: done, errors");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_item(u8u16_pkg::in_item_t it);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    book.predict_units(it);
    sent_bytes++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (book.pending() != 0);
  endtask

  // Mostly well-formed strings with random code points; some noise bytes and
  // sequences cut short. Overlong forms fall out of the random values.
  task automatic send_random_string();
    logic [7:0]          q[$];
    logic [20:0]         v;
    u8u16_pkg::in_item_t it;
    int                  n_cp;
    int                  kind;
    int                  len;
    n_cp = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
    for (int i = 0; i < n_cp; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        q = {q, 8'($urandom_range(0, 255))};
      end else begin
        len = $urandom_range(0, 99);
        len = (len < 40) ? 1 : (len < 60) ? 2 : (len < 80) ? 3 : 4;
        case (len)
          1: begin
            v = 21'($urandom_range(1, 127));
            q = {q, {1'b0, v[6:0]}};
          end
          2: begin
            v = 21'($urandom_range(0, 'h7FF));
            q = {q, u8u16_pkg::LEAD2_TAG | {3'b000, v[10:6]}};
            q = {q, u8u16_pkg::CONT_TAG | {2'b00, v[5:0]}};
          end
          3: begin
            v = 21'($urandom_range(0, 'hFFFF));
            q = {q, u8u16_pkg::LEAD3_TAG | {4'b0000, v[15:12]}};
            q = {q, u8u16_pkg::CONT_TAG | {2'b00, v[11:6]}};
            q = {q, u8u16_pkg::CONT_TAG | {2'b00, v[5:0]}};
          end
          default: begin
            v = ($urandom_range(0, 7) == 0) ? 21'($urandom_range(0, 'h1FFFFF))
                                            : 21'($urandom_range('h10000, 'h10FFFF));
            q = {q, u8u16_pkg::LEAD4_TAG | {5'b00000, v[20:18]}};
            q = {q, u8u16_pkg::CONT_TAG | {2'b00, v[17:12]}};
            q = {q, u8u16_pkg::CONT_TAG | {2'b00, v[11:6]}};
            q = {q, u8u16_pkg::CONT_TAG | {2'b00, v[5:0]}};
          end
        endcase
        if (kind < 14 && len > 1) begin
          repeat ($urandom_range(1, len - 1)) void'(q.pop_back());
        end
      end
    end
    if ($urandom_range(0, 99) < 55 || q.size() == 0) q = {q, 8'h00};
    for (int i = 0; i < q.size(); i++) begin
      it.byte_in     = q[i];
      it.string_last = (i == q.size() - 1);
      send_item(it);
    end
  endtask

  // Receiver: random stalls, calm stretches, and one long hold-off.
  initial begin
    int  stall_left;
    int  calm_left;
    int  r;
    bit  held;
    stall_left = 0;
    calm_left  = 0;
    held       = 1'b0;
    seen_units = 0;
    out_ready  = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        book.check_unit(out_data);
        seen_units++;
      end
      if (!held && seen_units >= 500) begin
        held       = 1'b1;
        stall_left = 300;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (calm_left > 0) begin
        calm_left--;
        out_ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          calm_left = $urandom_range(20, 80);
          out_ready <= 1'b1;
        end else if (r < 60) begin
          out_ready <= 1'b1;
        end else begin
          stall_left = (r < 88) ? $urandom_range(0, 2) :
                       (r < 97) ? $urandom_range(3, 10) : $urandom_range(20, 50);
          out_ready <= 1'b0;
        end
      end
    end
  end

  initial begin
    logic [8:0] directed[$];
    bit         paused;
    book       = new();
    sent_bytes = 0;
    no_idle    = 1'b0;
    paused     = 1'b0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // {byte, last}
    directed = '{
      {8'hDF, 1'b0}, {8'hBF, 1'b0},
      {8'hF4, 1'b0}, {8'h8F, 1'b0}, {8'hBF, 1'b0}, {8'hBF, 1'b0},
      {8'hF7, 1'b0}, {8'hBF, 1'b0}, {8'hBF, 1'b0}, {8'hBF, 1'b0},
      {8'hED, 1'b0}, {8'hA0, 1'b0}, {8'h80, 1'b0},
      {8'h80, 1'b0}, {8'hFF, 1'b0},
      {8'hC2, 1'b0}, {8'h41, 1'b0},
      {8'hE2, 1'b0}, {8'h00, 1'b0},
      {8'h00, 1'b0},
      {8'hC2, 1'b0}, {8'h00, 1'b1},
      {8'hE2, 1'b0}, {8'h82, 1'b1},
      {8'hF0, 1'b1},
      {8'h7F, 1'b0}, {8'h00, 1'b1}
    };
    foreach (directed[i]) send_item(u8u16_pkg::in_item_t'(directed[i]));
    wait_drained();

    while (sent_bytes < 1540) begin
      no_idle = ($urandom_range(0, 9) == 0);
      send_random_string();
      if (!paused && sent_bytes > 800) begin
        paused = 1'b1;
        wait_drained();
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (book.errors == 0 && book.pending() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/u8u16_pkg.sv
src/u8u16_decoder.sv
src/u8u16_out_buf.sv
src/utf8_to_utf16_transcoder_unit.sv
dv/testbench.sv
